>>> hw/rtl/bpa_pkg.sv
// package with types and constants of the bitmap page allocator
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    localparam int PAGE_COUNT_DEF = 16;
    localparam int PAGE_IDX_W     = 10;
    localparam int PAGES_FREE_W   = 11;
    localparam int TOTAL_W        = 32;
    localparam int WORD_W         = 16;
    localparam int ENC_W          = $clog2(WORD_W);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_FREE     = 2'd1,
        STATUS_INVALID     = 2'd2,
        STATUS_DOUBLE_FREE = 2'd3
    } status_t;

    typedef struct packed {
        op_t                   operation;
        logic [PAGE_IDX_W-1:0] page_index;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic [PAGE_IDX_W-1:0]   granted_page;
        logic [PAGES_FREE_W-1:0] pages_free;
        logic [TOTAL_W-1:0]      allocations_total;
        logic [TOTAL_W-1:0]      releases_total;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RELEASE
    } state_t;

    typedef struct packed {
        logic load;
        logic advance;
        logic grant;
        logic no_free;
        logic release_page;
    } dp_cmd_t;

    typedef struct packed {
        op_t  operation;
        logic full;
        logic word_hit;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/bitmap_page_allocator.sv
// top level of the bitmap first-fit page allocator
// a transaction is taken when start is high and busy is low
// free: busy in the scan and release states, result strobe (done) in the cycle after that
// allocate: busy in the scan state while the word encoder scans words of 16 pages, then the strobe
// no new transaction is taken while busy with the last one; the result cannot be stalled
// reset clears the used map (all pages free) and both totals
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator
#(
    parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire bpa_pkg::req_t req,
    output logic               busy,
    output logic               done,
    output bpa_pkg::rsp_t      rsp
);
    import bpa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bpa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    bpa_datapath
    #(
        .PAGE_COUNT (PAGE_COUNT)
    )
    u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

>>> hw/rtl/bpa_ctrl.sv
// controller state machine of the bitmap page allocator
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output bpa_pkg::dp_cmd_t       cmd,
    input  wire bpa_pkg::dp_stat_t stat
);
    import bpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.operation == OP_FREE)
                begin
                    state_next = ST_RELEASE;
                end
                else if (stat.full)
                begin
                    cmd.no_free = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (stat.word_hit)
                begin
                    cmd.grant  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_RELEASE:
            begin
                cmd.release_page = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/bpa_datapath.sv
// used-page bitmap, word scan, counters and result register
`timescale 1ns / 1ps
`default_nettype none

module bpa_datapath
#(
    parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bpa_pkg::req_t    req,
    input  wire bpa_pkg::dp_cmd_t cmd,
    output bpa_pkg::dp_stat_t     stat,
    output logic                  done,
    output bpa_pkg::rsp_t         rsp
);
    import bpa_pkg::*;

    localparam int NUM_WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
    localparam int PTR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(PAGE_COUNT + 1);

    logic [PAGE_COUNT-1:0]       used_reg;
    logic [PAGE_COUNT-1:0]       used_next;
    logic [CNT_W-1:0]            free_cnt_reg;
    logic [CNT_W-1:0]            free_cnt_next;
    logic [TOTAL_W-1:0]          alloc_cnt_reg;
    logic [TOTAL_W-1:0]          alloc_cnt_next;
    logic [TOTAL_W-1:0]          rel_cnt_reg;
    logic [TOTAL_W-1:0]          rel_cnt_next;
    logic [PTR_W-1:0]            ptr_reg;
    logic [PTR_W-1:0]            ptr_next;
    req_t                        req_reg;
    req_t                        req_next;
    rsp_t                        rsp_reg;
    rsp_t                        rsp_next;
    logic                        done_reg;
    logic                        done_next;
    logic [NUM_WORDS*WORD_W-1:0] padded;
    logic [WORD_W-1:0]           cur_word;
    logic [ENC_W-1:0]            enc;
    logic [PAGE_IDX_W-1:0]       grant_page;
    logic                        in_range;
    logic                        sel_used;

    // pages past the end read as used
    for (genvar k = 0; k < NUM_WORDS * WORD_W; k++)
    begin : g_pad
        if (k < PAGE_COUNT)
        begin : g_page
            assign padded[k] = used_reg[k];
        end
        else
        begin : g_fill
            assign padded[k] = 1'b1;
        end
    end

    assign cur_word   = padded[ptr_reg * WORD_W +: WORD_W];
    assign grant_page = PAGE_IDX_W'({ptr_reg, enc});
    assign in_range   = {1'b0, req_reg.page_index} < PAGES_FREE_W'(PAGE_COUNT);

    always_comb
    begin
        enc = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (!cur_word[j])
            begin
                enc = ENC_W'(j);
            end
        end
    end

    always_comb
    begin
        sel_used = 1'b0;
        for (int i = 0; i < PAGE_COUNT; i++)
        begin
            if (PAGE_IDX_W'(i) == req_reg.page_index)
            begin
                sel_used = used_reg[i];
            end
        end
    end

    assign stat.operation = req_reg.operation;
    assign stat.full      = (free_cnt_reg == '0);
    assign stat.word_hit  = ~&cur_word;

    always_comb
    begin
        used_next      = used_reg;
        free_cnt_next  = free_cnt_reg;
        alloc_cnt_next = alloc_cnt_reg;
        rel_cnt_next   = rel_cnt_reg;
        ptr_next       = ptr_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        done_next      = 1'b0;

        if (cmd.load)
        begin
            req_next = req;
            ptr_next = '0;
        end

        if (cmd.advance)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.grant)
        begin
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                if (PAGE_IDX_W'(i) == grant_page)
                begin
                    used_next[i] = 1'b1;
                end
            end
            free_cnt_next  = free_cnt_reg - 1'b1;
            alloc_cnt_next = alloc_cnt_reg + 1'b1;
        end

        if (cmd.release_page && in_range && sel_used)
        begin
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                if (PAGE_IDX_W'(i) == req_reg.page_index)
                begin
                    used_next[i] = 1'b0;
                end
            end
            free_cnt_next = free_cnt_reg + 1'b1;
            rel_cnt_next  = rel_cnt_reg + 1'b1;
        end

        if (cmd.grant || cmd.no_free || cmd.release_page)
        begin
            done_next                  = 1'b1;
            rsp_next.granted_page      = '0;
            rsp_next.pages_free        = PAGES_FREE_W'(free_cnt_next);
            rsp_next.allocations_total = alloc_cnt_next;
            rsp_next.releases_total    = rel_cnt_next;
            if (cmd.grant)
            begin
                rsp_next.status       = STATUS_OK;
                rsp_next.granted_page = grant_page;
            end
            else if (cmd.no_free)
            begin
                rsp_next.status = STATUS_NO_FREE;
            end
            else if (!in_range)
            begin
                rsp_next.status = STATUS_INVALID;
            end
            else if (!sel_used)
            begin
                rsp_next.status = STATUS_DOUBLE_FREE;
            end
            else
            begin
                rsp_next.status = STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            free_cnt_reg  <= CNT_W'(PAGE_COUNT);
            alloc_cnt_reg <= '0;
            rel_cnt_reg   <= '0;
            ptr_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            free_cnt_reg  <= free_cnt_next;
            alloc_cnt_reg <= alloc_cnt_next;
            rel_cnt_reg   <= rel_cnt_next;
            ptr_reg       <= ptr_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bpa_checker.sv
// port-level assertions of the bitmap page allocator and their bind
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker
(
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire bpa_pkg::req_t req,
    input wire logic          busy,
    input wire logic          done,
    input wire bpa_pkg::rsp_t rsp
);
    import bpa_pkg::*;

    logic unused_req;
    assign unused_req = ^req;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on two cycles in a row");

    a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != STATUS_OK || rsp.granted_page != '0)
            |-> rsp.granted_page == '0 || rsp.status == STATUS_OK)
        else $error("granted page nonzero on failed request");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
